@@ hw/rtl/pulsating_sphere_node_velocity_top_macros.svh @@
// Assertion macros for the pulsating sphere node velocity block.
`ifndef PULSATING_SPHERE_NODE_VELOCITY_TOP_MACROS_SVH
`define PULSATING_SPHERE_NODE_VELOCITY_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define PSNV_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("psnv: same-cycle check failed");

// Next-cycle implication, clocked on clk, quiet during reset.
`define PSNV_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("psnv: next-cycle check failed");

`endif

@@ hw/rtl/psnv_pkg.sv @@
// Shared types and constants of the pulsating sphere node velocity block.
package psnv_pkg;

	localparam int SQRT_STEPS   = 33;
	localparam int CORDIC_STEPS = 24;
	localparam int DIV_STEPS    = 31;

	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [30:0]        TWO_PI_Q28      = 31'd1686629713;
	localparam logic signed [33:0] Q_QUARTER       = 34'sd1073741824;
	localparam logic signed [33:0] Q_HALF          = 34'sd2147483648;

	typedef enum logic [2:0] {
		REG_START = 3'd0,
		REG_END   = 3'd1,
		REG_AMP   = 3'd2,
		REG_FREQ  = 3'd3,
		REG_CX    = 3'd4,
		REG_CY    = 3'd5,
		REG_CZ    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic             win;
		logic [2:0]       dneg;
		logic [2:0][32:0] mag;
	} geo_side_t;

	typedef struct packed {
		logic        win;
		logic        rzero;
		logic        sneg;
		logic [2:0]  dneg;
		logic [31:0] a;
		logic [34:0] omega;
	} scale_side_t;

	function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0: return 34'sd536870912;
			5'd1: return 34'sd316933406;
			5'd2: return 34'sd167458907;
			5'd3: return 34'sd85004756;
			5'd4: return 34'sd42667331;
			5'd5: return 34'sd21354465;
			5'd6: return 34'sd10679838;
			5'd7: return 34'sd5340245;
			5'd8: return 34'sd2670163;
			5'd9: return 34'sd1335087;
			5'd10: return 34'sd667544;
			5'd11: return 34'sd333772;
			5'd12: return 34'sd166886;
			5'd13: return 34'sd83443;
			5'd14: return 34'sd41722;
			5'd15: return 34'sd20861;
			5'd16: return 34'sd10430;
			5'd17: return 34'sd5215;
			5'd18: return 34'sd2608;
			5'd19: return 34'sd1304;
			5'd20: return 34'sd652;
			5'd21: return 34'sd326;
			5'd22: return 34'sd163;
			5'd23: return 34'sd81;
			default: return 34'sd0;
		endcase
	endfunction

endpackage

@@ hw/rtl/pulsating_sphere_node_velocity_top.sv @@
// Top level of the pulsating sphere node velocity pipeline.
//
// Input stream (s_*): one beat per mesh node, carrying the simulation time and
// the node position, all Q16.16. Output stream (m_*): one beat per input beat,
// in order, carrying the three saturated velocity components on tdata and the
// in-window and saturation flags on tuser.
// Configuration (cfg_*): index and data of one of seven registers; always ready.
// Write it only while the pipeline is empty.
// Throughput: one beat per cycle while the receiver does not stall; the
// 33-step square root, the 24-step CORDIC running beside it and the 31-step
// divider are each one stage per step.
// Reset clears all valid bits and loads the register defaults (window open
// over all time, zero amplitude, frequency and centre).
// When the receiver stalls with a beat waiting at the output, the whole
// pipeline freezes and s_tready drops; no beat is lost or repeated.
`include "pulsating_sphere_node_velocity_top_macros.svh"

module pulsating_sphere_node_velocity_top import psnv_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // sim_time, node_x, node_y, node_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // vel_x, vel_y, vel_z
	output logic [1:0]   m_tuser,  // in_window, saturated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int SH = 30 + FRAC_BITS;
	localparam int VW = 97 - SH;

	logic ce;
	logic [31:0] start_q, end_q, amp_q, freq_q, cx_q, cy_q, cz_q;
	logic [2:0][31:0] cen;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;

	logic [31:0]        t_s1;
	logic [2:0][31:0]   n_s1;
	logic               win_s2, win_s3, win_s4, win_s5;
	logic [2:0][32:0]   d_s2;
	logic [63:0]        prod_s2;
	logic [2:0][32:0]   mag_s3, mag_s4, mag_s5, mag_s7, mag_s8;
	logic [2:0]         dneg_s3, dneg_s4, dneg_s5;
	logic signed [33:0] q_s3, q_s4, q_s5;
	logic [2:0][65:0]   sq_s4;
	logic [65:0]        sum_s5;
	geo_side_t          side_s5;

	logic [31:0]        turn;
	logic signed [33:0] qw, qf;

	logic               sq_valid;
	logic [32:0]        sq_root;
	logic signed [33:0] sq_y;
	geo_side_t          sq_side;

	logic signed [33:0] ycl;
	logic [62:0]        om_full;
	logic               win_s7, rzero_s7, sneg_s7;
	logic [32:0]        r_s7, r_s8;
	logic [30:0]        sabs_s7;
	logic [31:0]        amag_s7;
	logic [34:0]        omega_s7, omega_s8, omega_s9;
	logic [2:0]         dneg_s7, dneg_s8;
	logic               win_s8, rzero_s8, sneg_s8;
	logic [62:0]        af_s8;
	scale_side_t        side_s8;

	logic               dv_valid;
	logic [2:0][30:0]   dv_quo;
	scale_side_t        dv_side;

	logic [2:0][30:0]   u;
	logic [2:0][62:0]   mprod;
	logic [2:0][61:0]   m_s9;
	logic [2:0]         neg_s9, neg_s10, neg_s11, neg_s12;
	logic               zero_s9, zero_s10, zero_s11, zero_s12;
	logic               win_s9, win_s10, win_s11, win_s12;
	logic [2:0][65:0]   pl_s10, ph_s10;
	logic [2:0][96:0]   full_s11;
	logic [2:0][31:0]   clip_s12;
	logic [2:0]         sat_s12;
	logic [2:0][VW-1:0] vm;
	logic [2:0][VW-1:0] lim;
	logic [2:0][31:0]   vel_s13;
	logic               win_s13, sat_s13;

	assign ce        = !v_s13 || m_tready;
	assign s_tready  = ce;
	assign cfg_ready = 1'b1;
	assign cen       = {cz_q, cy_q, cx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '1;
			amp_q   <= '0;
			freq_q  <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				REG_AMP:   amp_q   <= cfg_data;
				REG_FREQ:  freq_q  <= cfg_data;
				REG_CX:    cx_q    <= cfg_data;
				REG_CY:    cy_q    <= cfg_data;
				REG_CZ:    cz_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (ce) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s7  <= sq_valid;
			v_s8  <= v_s7;
			v_s9  <= dv_valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	if (2 * FRAC_BITS >= 32) begin : g_turn_hi
		assign turn = prod_s2[2*FRAC_BITS-32 +: 32];
	end else begin : g_turn_lo
		assign turn = {prod_s2[2*FRAC_BITS-1:0], {(32 - 2 * FRAC_BITS){1'b0}}};
	end

	always_comb begin
		qw = {{2{turn[31]}}, turn};
		if (qw > Q_QUARTER) begin
			qf = Q_HALF - qw;
		end else if (qw < -Q_QUARTER) begin
			qf = -Q_HALF - qw;
		end else begin
			qf = qw;
		end
	end

	// Front: window, offsets, phase, squares
	always_ff @(posedge clk) begin
		if (ce) begin
			t_s1 <= s_tdata[31:0];
			n_s1 <= s_tdata[127:32];

			win_s2  <= (t_s1 >= start_q) && (t_s1 <= end_q);
			prod_s2 <= {32'b0, freq_q} * {32'b0, t_s1};
			for (int k = 0; k < 3; k++) begin
				d_s2[k] <= {n_s1[k][31], n_s1[k]} - {cen[k][31], cen[k]};
			end

			win_s3 <= win_s2;
			q_s3   <= qf;
			for (int k = 0; k < 3; k++) begin
				mag_s3[k]  <= d_s2[k][32] ? 33'(~d_s2[k] + 33'd1) : d_s2[k];
				dneg_s3[k] <= d_s2[k][32];
			end

			win_s4  <= win_s3;
			q_s4    <= q_s3;
			mag_s4  <= mag_s3;
			dneg_s4 <= dneg_s3;
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= {33'b0, mag_s3[k]} * {33'b0, mag_s3[k]};
			end

			win_s5  <= win_s4;
			q_s5    <= q_s4;
			mag_s5  <= mag_s4;
			dneg_s5 <= dneg_s4;
			sum_s5  <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	assign side_s5 = '{win: win_s5, dneg: dneg_s5, mag: mag_s5};

	psnv_sqrt_sine u_sqrt_sine (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s5),
		.in_sum    (sum_s5),
		.in_q      (q_s5),
		.in_side   (side_s5),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_y     (sq_y),
		.out_side  (sq_side)
	);

	always_comb begin
		if (sq_y > Q_QUARTER) begin
			ycl = Q_QUARTER;
		end else if (sq_y < -Q_QUARTER) begin
			ycl = -Q_QUARTER;
		end else begin
			ycl = sq_y;
		end
	end

	assign om_full = {31'b0, freq_q} * {32'b0, TWO_PI_Q28};

	// Middle: radius check, sine magnitude, amplitude product, angular rate
	always_ff @(posedge clk) begin
		if (ce) begin
			win_s7   <= sq_side.win;
			dneg_s7  <= sq_side.dneg;
			mag_s7   <= sq_side.mag;
			r_s7     <= sq_root;
			rzero_s7 <= sq_root == '0;
			sneg_s7  <= ycl[33];
			sabs_s7  <= ycl[33] ? 31'(-ycl) : ycl[30:0];
			amag_s7  <= amp_q[31] ? 32'(~amp_q + 32'd1) : amp_q;
			omega_s7 <= om_full[62:28];

			win_s8   <= win_s7;
			dneg_s8  <= dneg_s7;
			mag_s8   <= mag_s7;
			r_s8     <= r_s7;
			rzero_s8 <= rzero_s7;
			sneg_s8  <= sneg_s7;
			omega_s8 <= omega_s7;
			af_s8    <= {31'b0, amag_s7} * {32'b0, sabs_s7};
		end
	end

	assign side_s8 = '{win: win_s8, rzero: rzero_s8, sneg: sneg_s8, dneg: dneg_s8,
		a: af_s8[61:30], omega: omega_s8};

	psnv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (v_s8),
		.in_mag    (mag_s8),
		.in_r      (r_s8),
		.in_side   (side_s8),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_side  (dv_side)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u[k]     = (dv_quo[k] > 31'd1073741824) ? 31'd1073741824 : dv_quo[k];
			mprod[k] = {31'b0, dv_side.a} * {32'b0, u[k]};
			vm[k]    = full_s11[k][96:SH];
			lim[k]   = {{(VW - 32){1'b0}}, neg_s11[k] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		end
	end

	// Back: scale, multiply by angular rate, shift, clip, sign
	always_ff @(posedge clk) begin
		if (ce) begin
			win_s9   <= dv_side.win;
			zero_s9  <= dv_side.rzero || !dv_side.win;
			omega_s9 <= dv_side.omega;
			for (int k = 0; k < 3; k++) begin
				m_s9[k]   <= mprod[k][61:0];
				neg_s9[k] <= amp_q[31] ^ dv_side.sneg ^ dv_side.dneg[k];
			end

			win_s10   <= win_s9;
			zero_s10  <= zero_s9;
			neg_s10   <= neg_s9;
			for (int k = 0; k < 3; k++) begin
				pl_s10[k] <= {35'b0, m_s9[k][30:0]} * {31'b0, omega_s9};
				ph_s10[k] <= {35'b0, m_s9[k][61:31]} * {31'b0, omega_s9};
			end

			win_s11  <= win_s10;
			zero_s11 <= zero_s10;
			neg_s11  <= neg_s10;
			for (int k = 0; k < 3; k++) begin
				full_s11[k] <= {31'b0, pl_s10[k]} + {ph_s10[k], 31'b0};
			end

			win_s12  <= win_s11;
			zero_s12 <= zero_s11;
			neg_s12  <= neg_s11;
			for (int k = 0; k < 3; k++) begin
				sat_s12[k]  <= vm[k] > lim[k];
				clip_s12[k] <= (vm[k] > lim[k]) ? lim[k][31:0] : vm[k][31:0];
			end

			win_s13 <= win_s12;
			sat_s13 <= !zero_s12 && (|sat_s12);
			for (int k = 0; k < 3; k++) begin
				if (zero_s12) begin
					vel_s13[k] <= '0;
				end else begin
					vel_s13[k] <= neg_s12[k] ? 32'(32'd0 - clip_s12[k]) : clip_s12[k];
				end
			end
		end
	end

	assign m_tvalid = v_s13;
	assign m_tdata  = vel_s13;
	assign m_tuser  = {sat_s13, win_s13};

	`PSNV_ASSERT_IMP(a_phase_folded, v_s3, (q_s3 <= Q_QUARTER) && (q_s3 >= -Q_QUARTER))
	`PSNV_ASSERT_IMP(a_quiet_outside, m_tvalid && !m_tuser[0],
		(m_tdata == '0) && !m_tuser[1])
	`PSNV_ASSERT_IMP(a_sat_at_limit, m_tvalid && m_tuser[1],
		(m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000) ||
		(m_tdata[63:32] == 32'h7FFF_FFFF) || (m_tdata[63:32] == 32'h8000_0000) ||
		(m_tdata[95:64] == 32'h7FFF_FFFF) || (m_tdata[95:64] == 32'h8000_0000))
	`PSNV_ASSERT_NEXT(a_tail_advance, v_s12 && ce, m_tvalid)

endmodule

@@ hw/rtl/psnv_sqrt_sine.sv @@
// Pipelined square root of the squared radius, with the CORDIC sine alongside.
module psnv_sqrt_sine import psnv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ce,
	input  logic                in_valid,
	input  logic [65:0]         in_sum,
	input  logic signed [33:0]  in_q,
	input  geo_side_t           in_side,
	output logic                out_valid,
	output logic [32:0]         out_root,
	output logic signed [33:0]  out_y,
	output geo_side_t           out_side
);

	logic               v_s    [SQRT_STEPS];
	logic [32:0]        root_s [SQRT_STEPS];
	logic [34:0]        rem_s  [SQRT_STEPS];
	logic [65:0]        sum_s  [SQRT_STEPS];
	logic signed [33:0] x_s    [SQRT_STEPS];
	logic signed [33:0] y_s    [SQRT_STEPS];
	logic signed [33:0] q_s    [SQRT_STEPS];
	geo_side_t          side_s [SQRT_STEPS];

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_st
		localparam int P = 2 * (SQRT_STEPS - 1 - g);
		logic               v_in;
		logic [32:0]        root_in;
		logic [34:0]        rem_in;
		logic [65:0]        sum_in;
		logic signed [33:0] x_in, y_in, q_in;
		geo_side_t          side_in;
		logic [36:0]        rem_sh, trial;
		logic               fits;
		logic signed [33:0] x_nx, y_nx, q_nx;

		if (g == 0) begin : g_head
			assign v_in    = in_valid;
			assign root_in = '0;
			assign rem_in  = '0;
			assign sum_in  = in_sum;
			assign x_in    = CORDIC_GAIN_Q30;
			assign y_in    = '0;
			assign q_in    = in_q;
			assign side_in = in_side;
		end else begin : g_link
			assign v_in    = v_s[g-1];
			assign root_in = root_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign sum_in  = sum_s[g-1];
			assign x_in    = x_s[g-1];
			assign y_in    = y_s[g-1];
			assign q_in    = q_s[g-1];
			assign side_in = side_s[g-1];
		end

		assign rem_sh = {rem_in, sum_in[P+1:P]};
		assign trial  = {2'b00, root_in, 2'b01};
		assign fits   = rem_sh >= trial;

		if (g < CORDIC_STEPS) begin : g_rot
			always_comb begin
				if (!q_in[33]) begin
					x_nx = x_in - (y_in >>> g);
					y_nx = y_in + (x_in >>> g);
					q_nx = q_in - atan_turn(5'(g));
				end else begin
					x_nx = x_in + (y_in >>> g);
					y_nx = y_in - (x_in >>> g);
					q_nx = q_in + atan_turn(5'(g));
				end
			end
		end else begin : g_hold
			assign x_nx = x_in;
			assign y_nx = y_in;
			assign q_nx = q_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (ce) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				root_s[g] <= {root_in[31:0], fits};
				rem_s[g]  <= fits ? 35'(rem_sh - trial) : rem_sh[34:0];
				sum_s[g]  <= sum_in;
				x_s[g]    <= x_nx;
				y_s[g]    <= y_nx;
				q_s[g]    <= q_nx;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = v_s[SQRT_STEPS-1];
	assign out_root  = root_s[SQRT_STEPS-1];
	assign out_y     = y_s[SQRT_STEPS-1];
	assign out_side  = side_s[SQRT_STEPS-1];

endmodule

@@ hw/rtl/psnv_div.sv @@
// Pipelined restoring divider: three offset magnitudes over the radius, Q1.30.
module psnv_div import psnv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_valid,
	input  logic [2:0][32:0] in_mag,
	input  logic [32:0]      in_r,
	input  scale_side_t      in_side,
	output logic             out_valid,
	output logic [2:0][30:0] out_quo,
	output scale_side_t      out_side
);

	logic             v_s    [DIV_STEPS];
	logic [2:0][32:0] rem_s  [DIV_STEPS];
	logic [2:0][30:0] quo_s  [DIV_STEPS];
	logic [32:0]      r_s    [DIV_STEPS];
	scale_side_t      side_s [DIV_STEPS];

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_st
		logic             v_in;
		logic [2:0][32:0] rem_in;
		logic [2:0][30:0] quo_in;
		logic [32:0]      r_in;
		scale_side_t      side_in;
		logic [2:0]       bit_in;
		logic [2:0][33:0] sh;
		logic [2:0]       fits;

		if (g == 0) begin : g_head
			assign v_in    = in_valid;
			assign r_in    = in_r;
			assign quo_in  = '0;
			assign side_in = in_side;
			for (genvar k = 0; k < 3; k++) begin : g_ln
				assign rem_in[k] = {1'b0, in_mag[k][32:1]};
				assign bit_in[k] = in_mag[k][0];
			end
		end else begin : g_link
			assign v_in    = v_s[g-1];
			assign r_in    = r_s[g-1];
			assign quo_in  = quo_s[g-1];
			assign side_in = side_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign bit_in  = '0;
		end

		for (genvar k = 0; k < 3; k++) begin : g_cmp
			assign sh[k]   = {rem_in[k], bit_in[k]};
			assign fits[k] = sh[k] >= {1'b0, r_in};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (ce) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				for (int k = 0; k < 3; k++) begin
					rem_s[g][k] <= fits[k] ? 33'(sh[k] - {1'b0, r_in}) : sh[k][32:0];
					quo_s[g][k] <= {quo_in[k][29:0], fits[k]};
				end
				r_s[g]    <= r_in;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS-1];
	assign out_quo   = quo_s[DIV_STEPS-1];
	assign out_side  = side_s[DIV_STEPS-1];

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the pulsating sphere node velocity pipeline.
`timescale 1ns / 100ps

module tb_top;
	import psnv_pkg::*;

	localparam int         FRAC_BITS   = 16;
	localparam int         LATENCY     = 76;
	localparam logic [2:0] REG_UNUSED  = 3'd7;
	localparam longint     GAIN_Q30    = 64'sd652032874;
	localparam longint     QUARTER_Q32 = 64'sd1073741824;
	localparam longint     HALF_Q32    = 64'sd2147483648;
	localparam longint     TWO_PI_F28  = 64'd1686629713;

	typedef struct packed {
		logic [31:0] node_z;
		logic [31:0] node_y;
		logic [31:0] node_x;
		logic [31:0] sim_time;
	} node_beat_t;

	typedef struct {
		logic [31:0] vel[3];
		logic        in_window;
		logic        saturated;
	} node_vel_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = REG_START;
	logic [31:0]  cfg_data = '0;

	logic [31:0]  shadow_regs[7];
	node_beat_t   pending_nodes[$];
	node_vel_t    expected_vel[$];
	int           nodes_queued = 0;
	int           vel_seen = 0;
	int           mismatches = 0;
	int           sat_seen = 0;
	int           win_seen = 0;
	bit           beat_taken = 1'b0;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           hold_cnt = 0;
	bit           hold_req = 1'b0;
	bit           idle_on = 1'b1;

	const longint atan_q32[24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	pulsating_sphere_node_velocity_top #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sine_q30(logic [31:0] turn);
		longint q, x, y, dx, dy;
		q = longint'(turn);
		x = GAIN_Q30;
		y = 0;
		if (q >= HALF_Q32) q -= 2 * HALF_Q32;
		if (q > QUARTER_Q32) q = HALF_Q32 - q;
		else if (q < -QUARTER_Q32) q = -HALF_Q32 - q;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (q >= 0) begin
				x -= dx; y += dy; q -= atan_q32[i];
			end else begin
				x += dx; y -= dy; q += atan_q32[i];
			end
		end
		if (y > QUARTER_Q32) y = QUARTER_Q32;
		if (y < -QUARTER_Q32) y = -QUARTER_Q32;
		return y;
	endfunction

	function automatic logic [127:0] isqrt(logic [127:0] v);
		logic [127:0] root, rem, trial;
		root = 0;
		rem = 0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic node_vel_t node_velocity(node_beat_t b);
		node_vel_t    res;
		longint       d[3], s, amp;
		logic [127:0] mag[3], sumsq, r, amag, smag, a, om, u, p, lim;
		logic [63:0]  prod;
		logic [31:0]  node[3];
		bit           neg;
		res.vel = '{32'd0, 32'd0, 32'd0};
		res.in_window = 1'b0;
		res.saturated = 1'b0;
		if (b.sim_time < shadow_regs[REG_START] || b.sim_time > shadow_regs[REG_END])
			return res;
		res.in_window = 1'b1;
		node = '{b.node_x, b.node_y, b.node_z};
		sumsq = 0;
		for (int k = 0; k < 3; k++) begin
			d[k] = longint'($signed(node[k])) - longint'($signed(shadow_regs[REG_CX + k]));
			mag[k] = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
			sumsq += mag[k] * mag[k];
		end
		r = isqrt(sumsq);
		if (r == 0) return res;
		prod = 64'(shadow_regs[REG_FREQ]) * 64'(b.sim_time);
		s = sine_q30(prod[31:0]);
		amp = longint'($signed(shadow_regs[REG_AMP]));
		amag = amp < 0 ? 128'(-amp) : 128'(amp);
		smag = s < 0 ? 128'(-s) : 128'(s);
		a = (amag * smag) >> 30;
		om = (128'(shadow_regs[REG_FREQ]) * 128'(TWO_PI_F28)) >> 28;
		for (int k = 0; k < 3; k++) begin
			u = (mag[k] << 30) / r;
			if (u > 128'd1073741824) u = 128'd1073741824;
			p = ((a * u) * om) >> (30 + FRAC_BITS);
			neg = ((amp < 0) != (s < 0)) != (d[k] < 0);
			lim = neg ? 128'd2147483648 : 128'd2147483647;
			if (p > lim) begin
				p = lim;
				res.saturated = 1'b1;
			end
			res.vel[k] = neg ? 32'(-p) : p[31:0];
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (!idle_on || roll < 55) return 0;
		if (roll < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// driver: hold an offered beat until taken
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !beat_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_nodes.size() > 0) begin
				s_tdata <= pending_nodes.pop_front();
				s_tvalid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_req = 1'b0;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			recv_gap = pick_gap();
		end
	end

	// monitor
	always @(posedge clk) begin
		node_vel_t exp_v;
		beat_taken = s_tvalid && s_tready;
		if (beat_taken) expected_vel.push_back(node_velocity(node_beat_t'(s_tdata)));
		if (m_tvalid && m_tready) begin
			vel_seen++;
			if (m_tuser[1]) sat_seen++;
			if (m_tuser[0]) win_seen++;
			if (expected_vel.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected velocity beat %h", m_tdata);
			end else begin
				exp_v = expected_vel.pop_front();
				if (m_tdata[31:0] !== exp_v.vel[0] || m_tdata[63:32] !== exp_v.vel[1] ||
						m_tdata[95:64] !== exp_v.vel[2] || m_tuser[0] !== exp_v.in_window ||
						m_tuser[1] !== exp_v.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d: exp v=%h %h %h w=%b s=%b, got v=%h %h %h w=%b s=%b",
							vel_seen, exp_v.vel[0], exp_v.vel[1], exp_v.vel[2],
							exp_v.in_window, exp_v.saturated, m_tdata[31:0],
							m_tdata[63:32], m_tdata[95:64], m_tuser[0], m_tuser[1]);
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_CZ) shadow_regs[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_regs(logic [31:0] t0, logic [31:0] t1, logic [31:0] amp,
			logic [31:0] f, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		write_reg(REG_START, t0);
		write_reg(REG_END, t1);
		write_reg(REG_AMP, amp);
		write_reg(REG_FREQ, f);
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
		write_reg(REG_CZ, cz);
	endtask

	task automatic queue_node(logic [31:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		pending_nodes.push_back('{node_z: z, node_y: y, node_x: x, sim_time: t});
		nodes_queued++;
	endtask

	task automatic drain();
		wait (vel_seen == nodes_queued);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] near(logic [31:0] c);
		return c + 32'($signed($urandom_range(2000)) - 1000);
	endfunction

	task automatic queue_random(int n);
		logic [31:0] t, x, y, z;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) t = $urandom();
			else t = $urandom_range(shadow_regs[REG_END], shadow_regs[REG_START]);
			case ($urandom_range(3))
				0: begin x = $urandom(); y = $urandom(); z = $urandom(); end
				1: begin
					x = near(shadow_regs[REG_CX]);
					y = near(shadow_regs[REG_CY]);
					z = near(shadow_regs[REG_CZ]);
				end
				2: begin
					x = shadow_regs[REG_CX] + ($urandom() >>> $urandom_range(31));
					y = shadow_regs[REG_CY] + ($urandom() >>> $urandom_range(31));
					z = shadow_regs[REG_CZ] + ($urandom() >>> $urandom_range(31));
				end
				default: begin
					x = shadow_regs[REG_CX];
					y = shadow_regs[REG_CY];
					z = $urandom_range(1) ? shadow_regs[REG_CZ] : $urandom();
				end
			endcase
			queue_node(t, x, y, z);
		end
	endtask

	initial begin
		shadow_regs = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults, then full-scale amplitude at the extremes
		queue_node(32'd0, 32'h0001_0000, 32'd0, 32'd0);
		drain();
		load_regs(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_8000, 32'd0, 32'd0, 32'd0);
		queue_node(32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
		queue_node(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		queue_node(32'h0000_4000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_node(32'h0000_8000, 32'd0, 32'd0, 32'd0);
		queue_node(32'h0001_4000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0);
		queue_node(32'h0000_2AAA, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000);
		drain();
		load_regs(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		queue_node(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
		queue_node(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_node(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
		queue_node(32'hC000_1234, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		drain();
		// empty window, then tight window edges; index beyond range ignored
		load_regs(32'd200, 32'd100, 32'h0010_0000, 32'h0002_0000, 32'd0, 32'd0, 32'd0);
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		queue_node(32'd150, 32'h0001_0000, 32'd0, 32'd0);
		queue_node(32'd100, 32'h0001_0000, 32'd0, 32'd0);
		queue_node(32'd200, 32'h0001_0000, 32'd0, 32'd0);
		drain();
		load_regs(32'd1000, 32'd2000, 32'h0010_0000, 32'h0002_0000, 32'd0, 32'd0, 32'd0);
		queue_node(32'd999, 32'h0001_0000, 32'd0, 32'd0);
		queue_node(32'd1000, 32'h0001_0000, 32'd0, 32'd0);
		queue_node(32'd2000, 32'd0, 32'h0001_0000, 32'd0);
		queue_node(32'd2001, 32'd0, 32'd0, 32'h0001_0000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			logic [31:0] t0, t1;
			t0 = $urandom_range(3) == 0 ? 32'd0 : $urandom();
			t1 = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom();
			if (t0 > t1 && $urandom_range(4) != 0) {t0, t1} = {t1, t0};
			case (ph % 4)
				0: load_regs(t0, t1, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				1: load_regs(t0, t1, $urandom_range(32'h0004_0000) - 32'h0002_0000,
					$urandom_range(32'h000A_0000), $urandom_range(32'h0010_0000),
					-$urandom_range(32'h0010_0000), $urandom_range(32'h0001_0000));
				2: load_regs(t0, t1, 32'h8000_0000, 32'hFFFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
				default: load_regs(t0, t1, 32'h7FFF_FFFF, $urandom_range(32'h0100_0000),
					$urandom(), $urandom(), $urandom());
			endcase
			idle_on = (ph != 3);
			queue_random(50);
			if (ph == 5) hold_req = 1'b1;
			drain();
		end

		$display("velocity beats checked: %0d (%0d inside window, %0d saturated)",
			vel_seen, win_seen, sat_seen);
		$display("covered reset defaults, extremes, empty and edge windows, node at centre");
		if (mismatches == 0 && expected_vel.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
